// ===== hw/rtl/c8080_pkg.sv =====
`default_nettype none

package c8080_pkg;

    // Default memory size in bytes
    localparam int MEM_BYTES_DEF = 65536;

    // Input beat kinds (s_axis_tuser)
    localparam logic IN_STORE = 1'b0;
    localparam logic IN_EXEC  = 1'b1;

    // Supported opcodes
    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_LXI_B = 8'h01;
    localparam logic [7:0] OP_MOV_BC = 8'h41;
    localparam logic [7:0] OP_MOV_BD = 8'h42;
    localparam logic [7:0] OP_MOV_BE = 8'h43;
    localparam logic [7:0] OP_CMA   = 8'h2F;
    localparam logic [7:0] OP_ANI   = 8'hE6;
    localparam logic [7:0] OP_RRC   = 8'h0F;
    localparam logic [7:0] OP_RAR   = 8'h1F;
    localparam logic [7:0] OP_CPI   = 8'hFE;
    localparam logic [7:0] OP_ADD_B = 8'h80;
    localparam logic [7:0] OP_ADD_C = 8'h81;
    localparam logic [7:0] OP_ADD_M = 8'h86;
    localparam logic [7:0] OP_JNZ   = 8'hC2;
    localparam logic [7:0] OP_JMP   = 8'hC3;
    localparam logic [7:0] OP_CALL  = 8'hCD;
    localparam logic [7:0] OP_RET   = 8'hC9;

    // Flag bit positions
    localparam int FL_Z  = 0;
    localparam int FL_S  = 1;
    localparam int FL_P  = 2;
    localparam int FL_CY = 3;

    // General register indexes
    localparam logic [2:0] GP_B = 3'd0;
    localparam logic [2:0] GP_C = 3'd1;
    localparam logic [2:0] GP_H = 3'd4;
    localparam logic [2:0] GP_L = 3'd5;

    // Microcode addresses
    typedef logic [4:0] upc_t;

    localparam upc_t U_STORE  = 5'd0;
    localparam upc_t U_HALTED = 5'd1;
    localparam upc_t U_FETCH  = 5'd2;
    localparam upc_t U_FETCH2 = 5'd3;
    localparam upc_t X_NOP    = 5'd4;
    localparam upc_t X_MOV    = 5'd5;
    localparam upc_t X_CMA    = 5'd6;
    localparam upc_t X_RRC    = 5'd7;
    localparam upc_t X_RAR    = 5'd8;
    localparam upc_t X_ADDR   = 5'd9;
    localparam upc_t X_ADDM1  = 5'd10;
    localparam upc_t X_ADDM2  = 5'd11;
    localparam upc_t X_ANI    = 5'd12;
    localparam upc_t X_CPI    = 5'd13;
    localparam upc_t X_LXI1   = 5'd14;
    localparam upc_t X_LXI2   = 5'd15;
    localparam upc_t X_JMP1   = 5'd16;
    localparam upc_t X_JNZ    = 5'd17;
    localparam upc_t X_JMP2   = 5'd18;
    localparam upc_t X_SKIP3  = 5'd19;
    localparam upc_t X_CALL1  = 5'd20;
    localparam upc_t X_CALL2  = 5'd21;
    localparam upc_t X_CALL3  = 5'd22;
    localparam upc_t X_RET1   = 5'd23;
    localparam upc_t X_RET2   = 5'd24;
    localparam upc_t X_RET3   = 5'd25;
    localparam upc_t X_BAD    = 5'd26;

    // Control word fields
    typedef enum logic [1:0] {MEM_IDLE, MEM_RD, MEM_WR} mem_op_t;

    typedef enum logic [3:0] {
        A_PC, A_PC1, A_PC2, A_HL, A_SP, A_SP1, A_SPM1, A_SPM2, A_IN
    } addr_sel_t;

    typedef enum logic [1:0] {WD_IN, WD_RET_HI, WD_RET_LO} wd_sel_t;

    typedef enum logic [1:0] {LD_NONE, LD_OP, LD_LO, LD_HI} ld_sel_t;

    typedef enum logic [3:0] {
        ALU_NONE, ALU_MOV, ALU_CMA, ALU_RRC, ALU_RAR,
        ALU_ADD, ALU_ANI, ALU_CPI, ALU_LDC, ALU_LDB
    } alu_op_t;

    typedef enum logic {OPND_MEM, OPND_REG} opnd_sel_t;

    typedef enum logic [2:0] {
        PC_KEEP, PC_INC1, PC_INC2, PC_INC3, PC_JUMP, PC_HILO
    } pc_sel_t;

    typedef enum logic [1:0] {SP_KEEP, SP_DEC2, SP_INC2} sp_sel_t;

    typedef enum logic [1:0] {
        ST_EXEC  = 2'd0,
        ST_STORE = 2'd1,
        ST_HALT  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        SEQ_NEXT, SEQ_DISPATCH, SEQ_GOTO, SEQ_GOTO_Z, SEQ_END
    } seq_t;

    typedef struct packed {
        mem_op_t   mem_op;
        addr_sel_t addr_sel;
        wd_sel_t   wd_sel;
        ld_sel_t   ld_sel;
        alu_op_t   alu_op;
        opnd_sel_t opnd_sel;
        pc_sel_t   pc_sel;
        sp_sel_t   sp_sel;
        logic      set_halt;
        status_t   status;
        seq_t      seq;
        upc_t      target;
    } cw_t;

    // Zero, sign and even parity of a result: {P, S, Z}
    function automatic logic [2:0] zsp(input logic [7:0] v);
        zsp = {~^v, v[7], (v == 8'd0)};
    endfunction

    // Opcode to first step of its routine
    function automatic upc_t dispatch(input logic [7:0] op);
        case (op)
            OP_NOP:    dispatch = X_NOP;
            OP_LXI_B:  dispatch = X_LXI1;
            OP_MOV_BC: dispatch = X_MOV;
            OP_MOV_BD: dispatch = X_MOV;
            OP_MOV_BE: dispatch = X_MOV;
            OP_CMA:    dispatch = X_CMA;
            OP_ANI:    dispatch = X_ANI;
            OP_RRC:    dispatch = X_RRC;
            OP_RAR:    dispatch = X_RAR;
            OP_CPI:    dispatch = X_CPI;
            OP_ADD_B:  dispatch = X_ADDR;
            OP_ADD_C:  dispatch = X_ADDR;
            OP_ADD_M:  dispatch = X_ADDM1;
            OP_JNZ:    dispatch = X_JNZ;
            OP_JMP:    dispatch = X_JMP1;
            OP_CALL:   dispatch = X_CALL1;
            OP_RET:    dispatch = X_RET1;
            default:   dispatch = X_BAD;
        endcase
    endfunction

    // Microprogram ROM
    function automatic cw_t ucode_rom(input upc_t a);
        cw_t cw;
        cw.mem_op   = MEM_IDLE;
        cw.addr_sel = A_PC;
        cw.wd_sel   = WD_IN;
        cw.ld_sel   = LD_NONE;
        cw.alu_op   = ALU_NONE;
        cw.opnd_sel = OPND_MEM;
        cw.pc_sel   = PC_KEEP;
        cw.sp_sel   = SP_KEEP;
        cw.set_halt = 1'b0;
        cw.status   = ST_EXEC;
        cw.seq      = SEQ_END;
        cw.target   = U_STORE;
        case (a)
            U_STORE:
            begin
                cw.mem_op   = MEM_WR;
                cw.addr_sel = A_IN;
                cw.status   = ST_STORE;
            end
            U_HALTED:
            begin
                cw.status = ST_HALT;
            end
            U_FETCH:
            begin
                cw.mem_op = MEM_RD;
                cw.seq    = SEQ_NEXT;
            end
            // opcode arrives; the byte after it is read speculatively
            U_FETCH2:
            begin
                cw.mem_op   = MEM_RD;
                cw.addr_sel = A_PC1;
                cw.ld_sel   = LD_OP;
                cw.seq      = SEQ_DISPATCH;
            end
            X_NOP:
            begin
                cw.pc_sel = PC_INC1;
            end
            X_MOV:
            begin
                cw.alu_op   = ALU_MOV;
                cw.opnd_sel = OPND_REG;
                cw.pc_sel   = PC_INC1;
            end
            X_CMA:
            begin
                cw.alu_op = ALU_CMA;
                cw.pc_sel = PC_INC1;
            end
            X_RRC:
            begin
                cw.alu_op = ALU_RRC;
                cw.pc_sel = PC_INC1;
            end
            X_RAR:
            begin
                cw.alu_op = ALU_RAR;
                cw.pc_sel = PC_INC1;
            end
            X_ADDR:
            begin
                cw.alu_op   = ALU_ADD;
                cw.opnd_sel = OPND_REG;
                cw.pc_sel   = PC_INC1;
            end
            X_ADDM1:
            begin
                cw.mem_op   = MEM_RD;
                cw.addr_sel = A_HL;
                cw.seq      = SEQ_NEXT;
            end
            X_ADDM2:
            begin
                cw.alu_op = ALU_ADD;
                cw.pc_sel = PC_INC1;
            end
            X_ANI:
            begin
                cw.alu_op = ALU_ANI;
                cw.pc_sel = PC_INC2;
            end
            X_CPI:
            begin
                cw.alu_op = ALU_CPI;
                cw.pc_sel = PC_INC2;
            end
            X_LXI1:
            begin
                cw.mem_op   = MEM_RD;
                cw.addr_sel = A_PC2;
                cw.alu_op   = ALU_LDC;
                cw.seq      = SEQ_NEXT;
            end
            X_LXI2:
            begin
                cw.alu_op = ALU_LDB;
                cw.pc_sel = PC_INC3;
            end
            X_JMP1:
            begin
                cw.mem_op   = MEM_RD;
                cw.addr_sel = A_PC2;
                cw.ld_sel   = LD_LO;
                cw.seq      = SEQ_GOTO;
                cw.target   = X_JMP2;
            end
            // falls into X_JMP2 unless zero is set
            X_JNZ:
            begin
                cw.mem_op   = MEM_RD;
                cw.addr_sel = A_PC2;
                cw.ld_sel   = LD_LO;
                cw.seq      = SEQ_GOTO_Z;
                cw.target   = X_SKIP3;
            end
            X_JMP2:
            begin
                cw.pc_sel = PC_JUMP;
            end
            X_SKIP3:
            begin
                cw.pc_sel = PC_INC3;
            end
            X_CALL1:
            begin
                cw.mem_op   = MEM_RD;
                cw.addr_sel = A_PC2;
                cw.ld_sel   = LD_LO;
                cw.seq      = SEQ_NEXT;
            end
            X_CALL2:
            begin
                cw.mem_op   = MEM_WR;
                cw.addr_sel = A_SPM1;
                cw.wd_sel   = WD_RET_HI;
                cw.ld_sel   = LD_HI;
                cw.seq      = SEQ_NEXT;
            end
            X_CALL3:
            begin
                cw.mem_op   = MEM_WR;
                cw.addr_sel = A_SPM2;
                cw.wd_sel   = WD_RET_LO;
                cw.pc_sel   = PC_HILO;
                cw.sp_sel   = SP_DEC2;
            end
            X_RET1:
            begin
                cw.mem_op   = MEM_RD;
                cw.addr_sel = A_SP;
                cw.seq      = SEQ_NEXT;
            end
            X_RET2:
            begin
                cw.mem_op   = MEM_RD;
                cw.addr_sel = A_SP1;
                cw.ld_sel   = LD_LO;
                cw.seq      = SEQ_NEXT;
            end
            X_RET3:
            begin
                cw.pc_sel = PC_JUMP;
                cw.sp_sel = SP_INC2;
            end
            X_BAD:
            begin
                cw.set_halt = 1'b1;
                cw.status   = ST_HALT;
            end
            default:
            begin
                cw.status = ST_HALT;
            end
        endcase
        ucode_rom = cw;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cpu8080_subset_step.sv =====
// 8080 subset stepper with internal byte memory.
// Input stream (s_axis): each beat is one step. tuser = 0 stores tdata's data
// byte at tdata's address; tuser = 1 executes the instruction at the program
// counter. Output stream (m_axis): one beat per input beat, carrying the step
// status in tuser and the registers after the step in tdata.
// The block works on one beat at a time, driven by a microprogram over a
// single-port memory with registered read data. Each memory access costs one
// micro-step; the step count is set by the opcode fetch plus the operand and
// stack accesses.
// A finished result sits in an output register, so the next beat is taken
// while it waits; if the receiver still stalls when the next result is ready,
// the sequencer holds on its last step until the output register frees.
// Reset clears the registers, flags, halt state and both handshakes; memory
// contents are not cleared and must be written before they are executed.
`default_nettype none

module cpu8080_subset_step #(
    parameter int MEM_BYTES = c8080_pkg::MEM_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [15:0] address, [23:16] data
    input  wire logic        s_axis_tuser,  // [0] beat kind: 0 store, 1 execute
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // [15:0] prog_counter, [31:16] stack_ptr,
                                            // [39:32] acc, [47:40] reg_b_out,
                                            // [55:48] reg_c_out, [59:56] flag_bits,
                                            // [63:60] zero
    output logic [1:0]       m_axis_tuser   // [1:0] status
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam bit MEM_POW2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);

    // Sequencer and architectural state
    logic                busy_reg, busy_next;
    c8080_pkg::upc_t     upc_reg, upc_next;
    logic [7:0]          acc_reg, acc_next;
    logic [7:0]          gp_reg [6];
    logic [7:0]          gp_next [6];
    logic [15:0]         pc_reg, pc_next;
    logic [15:0]         sp_reg, sp_next;
    logic [3:0]          flags_reg, flags_next;
    logic                halt_reg, halt_next;

    // Datapath holding registers
    logic [7:0]          op_reg;
    logic [7:0]          lo_reg;
    logic [7:0]          hi_reg;
    logic [15:0]         in_addr_reg;
    logic [7:0]          in_data_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    c8080_pkg::status_t  out_status_reg;
    logic [15:0]         out_pc_reg;
    logic [15:0]         out_sp_reg;
    logic [7:0]          out_acc_reg;
    logic [7:0]          out_b_reg;
    logic [7:0]          out_c_reg;
    logic [3:0]          out_flags_reg;

    // Memory
    logic [7:0]          mem [MEM_BYTES];
    logic [7:0]          rdata_reg;
    logic [15:0]         mem_addr;
    logic [AW-1:0]       mem_idx;
    logic [7:0]          mem_wdata;
    logic [15:0]         ret_addr;

    c8080_pkg::cw_t      cw;
    logic                s_fire;
    logic                step_go;
    logic                step_end;
    logic [7:0]          opnd;
    logic [8:0]          sum9;
    logic [8:0]          diff9;
    logic [7:0]          and8;

    // Current control word
    assign cw = c8080_pkg::ucode_rom(upc_reg);

    // Handshakes; the last step waits while the output register is still full
    assign s_axis_tready = !busy_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign step_end      = (cw.seq == c8080_pkg::SEQ_END);
    assign step_go       = busy_reg && !(step_end && out_valid_reg && !m_axis_tready);

    // Memory address select
    assign ret_addr = pc_reg + 16'd3;

    always_comb
    begin
        case (cw.addr_sel)
            c8080_pkg::A_PC:   mem_addr = pc_reg;
            c8080_pkg::A_PC1:  mem_addr = pc_reg + 16'd1;
            c8080_pkg::A_PC2:  mem_addr = pc_reg + 16'd2;
            c8080_pkg::A_HL:   mem_addr = {gp_reg[c8080_pkg::GP_H], gp_reg[c8080_pkg::GP_L]};
            c8080_pkg::A_SP:   mem_addr = sp_reg;
            c8080_pkg::A_SP1:  mem_addr = sp_reg + 16'd1;
            c8080_pkg::A_SPM1: mem_addr = sp_reg - 16'd1;
            c8080_pkg::A_SPM2: mem_addr = sp_reg - 16'd2;
            c8080_pkg::A_IN:   mem_addr = in_addr_reg;
            default:           mem_addr = pc_reg;
        endcase
    end

    // Address wraps modulo the memory size
    generate
        if (MEM_POW2)
        begin : g_idx_mask
            assign mem_idx = mem_addr[AW-1:0];
        end
        else
        begin : g_idx_reduce
            logic [23:0] red_val;
            // quotient fits in 8 bits when the memory holds at least 256 bytes; nothing here enforces that
            always_comb
            begin
                red_val = {8'd0, mem_addr};
                for (int k = 7; k >= 0; k--)
                begin
                    if (red_val >= (24'(MEM_BYTES) << k))
                        red_val = red_val - (24'(MEM_BYTES) << k);
                end
            end
            assign mem_idx = red_val[AW-1:0];
        end
    endgenerate

    // Write data select
    always_comb
    begin
        case (cw.wd_sel)
            c8080_pkg::WD_IN:     mem_wdata = in_data_reg;
            c8080_pkg::WD_RET_HI: mem_wdata = ret_addr[15:8];
            c8080_pkg::WD_RET_LO: mem_wdata = ret_addr[7:0];
            default:              mem_wdata = in_data_reg;
        endcase
    end

    // Single-port memory with registered read data
    always_ff @(posedge clk)
    begin
        if (step_go && cw.mem_op == c8080_pkg::MEM_WR)
            mem[mem_idx] <= mem_wdata;
        if (step_go && cw.mem_op == c8080_pkg::MEM_RD)
            rdata_reg <= mem[mem_idx];
    end

    // ALU operand and results
    assign opnd  = (cw.opnd_sel == c8080_pkg::OPND_REG) ? gp_reg[{1'b0, op_reg[1:0]}]
                                                        : rdata_reg;
    assign sum9  = {1'b0, acc_reg} + {1'b0, opnd};
    assign diff9 = {1'b0, acc_reg} - {1'b0, opnd};
    assign and8  = acc_reg & opnd;

    // Register and flag updates
    always_comb
    begin
        acc_next   = acc_reg;
        gp_next    = gp_reg;
        flags_next = flags_reg;
        if (step_go)
        begin
            case (cw.alu_op)
                c8080_pkg::ALU_NONE: ;
                c8080_pkg::ALU_MOV:  gp_next[c8080_pkg::GP_B] = opnd;
                c8080_pkg::ALU_CMA:  acc_next = ~acc_reg;
                c8080_pkg::ALU_RRC:
                begin
                    acc_next = {acc_reg[0], acc_reg[7:1]};
                    flags_next[c8080_pkg::FL_CY] = acc_reg[0];
                end
                c8080_pkg::ALU_RAR:
                begin
                    acc_next = {flags_reg[c8080_pkg::FL_CY], acc_reg[7:1]};
                    flags_next[c8080_pkg::FL_CY] = acc_reg[0];
                end
                c8080_pkg::ALU_ADD:
                begin
                    acc_next   = sum9[7:0];
                    flags_next = {sum9[8], c8080_pkg::zsp(sum9[7:0])};
                end
                c8080_pkg::ALU_ANI:
                begin
                    acc_next   = and8;
                    flags_next = {1'b0, c8080_pkg::zsp(and8)};
                end
                // compare: flags only, carry is the borrow
                c8080_pkg::ALU_CPI:  flags_next = {diff9[8], c8080_pkg::zsp(diff9[7:0])};
                c8080_pkg::ALU_LDC:  gp_next[c8080_pkg::GP_C] = opnd;
                c8080_pkg::ALU_LDB:  gp_next[c8080_pkg::GP_B] = opnd;
                default: ;
            endcase
        end
    end

    // Program counter, stack pointer and halt updates
    always_comb
    begin
        pc_next   = pc_reg;
        sp_next   = sp_reg;
        halt_next = halt_reg;
        if (step_go)
        begin
            case (cw.pc_sel)
                c8080_pkg::PC_KEEP: pc_next = pc_reg;
                c8080_pkg::PC_INC1: pc_next = pc_reg + 16'd1;
                c8080_pkg::PC_INC2: pc_next = pc_reg + 16'd2;
                c8080_pkg::PC_INC3: pc_next = pc_reg + 16'd3;
                c8080_pkg::PC_JUMP: pc_next = {rdata_reg, lo_reg};
                c8080_pkg::PC_HILO: pc_next = {hi_reg, lo_reg};
                default:            pc_next = pc_reg;
            endcase
            case (cw.sp_sel)
                c8080_pkg::SP_KEEP: sp_next = sp_reg;
                c8080_pkg::SP_DEC2: sp_next = sp_reg - 16'd2;
                c8080_pkg::SP_INC2: sp_next = sp_reg + 16'd2;
                default:            sp_next = sp_reg;
            endcase
            if (cw.set_halt)
                halt_next = 1'b1;
        end
    end

    // Sequencer: start routine on accept, then follow the control word
    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (s_fire)
        begin
            busy_next = 1'b1;
            if (s_axis_tuser == c8080_pkg::IN_STORE)
                upc_next = c8080_pkg::U_STORE;
            else if (halt_reg)
                upc_next = c8080_pkg::U_HALTED;
            else
                upc_next = c8080_pkg::U_FETCH;
        end
        else if (step_go)
        begin
            case (cw.seq)
                c8080_pkg::SEQ_NEXT:     upc_next = upc_reg + 5'd1;
                c8080_pkg::SEQ_DISPATCH: upc_next = c8080_pkg::dispatch(rdata_reg);
                c8080_pkg::SEQ_GOTO:     upc_next = cw.target;
                c8080_pkg::SEQ_GOTO_Z:
                begin
                    if (flags_reg[c8080_pkg::FL_Z])
                        upc_next = cw.target;
                    else
                        upc_next = upc_reg + 5'd1;
                end
                c8080_pkg::SEQ_END:      busy_next = 1'b0;
                default:                 busy_next = 1'b0;
            endcase
        end
    end

    // Output valid: set by a finishing step, cleared by a taken beat
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_go && step_end)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            upc_reg       <= c8080_pkg::U_FETCH;
            acc_reg       <= 8'd0;
            gp_reg        <= '{default: 8'd0};
            pc_reg        <= 16'd0;
            sp_reg        <= 16'd0;
            flags_reg     <= 4'd0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            upc_reg       <= upc_next;
            acc_reg       <= acc_next;
            gp_reg        <= gp_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            flags_reg     <= flags_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_addr_reg <= s_axis_tdata[15:0];
            in_data_reg <= s_axis_tdata[23:16];
        end
        if (step_go)
        begin
            case (cw.ld_sel)
                c8080_pkg::LD_NONE: ;
                c8080_pkg::LD_OP:   op_reg <= rdata_reg;
                c8080_pkg::LD_LO:   lo_reg <= rdata_reg;
                c8080_pkg::LD_HI:   hi_reg <= rdata_reg;
                default: ;
            endcase
        end
        if (step_go && step_end)
        begin
            out_status_reg <= cw.status;
            out_pc_reg     <= pc_next;
            out_sp_reg     <= sp_next;
            out_acc_reg    <= acc_next;
            out_b_reg      <= gp_next[c8080_pkg::GP_B];
            out_c_reg      <= gp_next[c8080_pkg::GP_C];
            out_flags_reg  <= flags_next;
        end
    end

    // Output beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {4'd0, out_flags_reg, out_c_reg, out_b_reg, out_acc_reg,
                            out_sp_reg, out_pc_reg};

endmodule

`default_nettype wire

// ===== dv/cpu8080_subset_step_check.sv =====
module cpu8080_subset_step_check (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] data
    input  wire logic        s_axis_tuser,   // [0] beat kind: 0 store, 1 execute
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,   // [15:0] prog_counter, [31:16] stack_ptr,
                                             // [39:32] acc, [47:40] reg_b_out,
                                             // [55:48] reg_c_out, [59:56] flag_bits
    input  wire logic [1:0]  m_axis_tuser,   // [1:0] status
    output int               mismatches,
    output int               outstanding,
    output logic [15:0]      pc_now,
    output logic [15:0]      sp_now
);
    import c8080_pkg::*;

    localparam logic [2:0] GP_D = 3'd2;
    localparam logic [2:0] GP_E = 3'd3;

    // architectural view after one step, as carried by a result beat
    typedef struct packed {
        status_t     status;
        logic [15:0] pc;
        logic [15:0] sp;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [3:0]  flags;
    } cpu_view_t;

    // shadow machine
    logic [7:0]  acc_m;
    logic [7:0]  gpr_m [0:5];
    logic [15:0] pc_m;
    logic [15:0] sp_m;
    logic [3:0]  flags_m;
    logic        halted_m;
    logic [7:0]  ram_m [0:65535];

    cpu_view_t expected_steps [$];

    assign pc_now = pc_m;
    assign sp_now = sp_m;

    // zero, sign and even parity from v; carry kept
    function automatic logic [3:0] flags_from(input logic [3:0] old, input logic [7:0] v);
        logic [3:0] f;
        f = old;
        f[FL_Z] = (v == 8'h00);
        f[FL_S] = v[7];
        f[FL_P] = ~^v;
        return f;
    endfunction

    task automatic add_to_acc(input logic [7:0] operand);
        logic [8:0] sum;
        sum = {1'b0, acc_m} + {1'b0, operand};
        acc_m = sum[7:0];
        flags_m = flags_from(flags_m, acc_m);
        flags_m[FL_CY] = sum[8];
    endtask

    // one store or one instruction on the shadow machine
    task automatic step_cpu(input logic kind, input logic [15:0] addr, input logic [7:0] din,
                            output cpu_view_t v);
        logic [7:0]  op;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  x;
        logic [7:0]  diff;
        logic [15:0] pc1;
        logic [15:0] pc2;
        logic [15:0] nxt;
        logic [15:0] ret_addr;
        status_t     st;
        st = ST_EXEC;
        if (kind == IN_STORE)
        begin
            ram_m[addr] = din;
            st = ST_STORE;
        end
        else if (halted_m)
        begin
            st = ST_HALT;
        end
        else
        begin
            pc1 = pc_m + 16'd1;
            pc2 = pc_m + 16'd2;
            op  = ram_m[pc_m];
            b1  = ram_m[pc1];
            b2  = ram_m[pc2];
            nxt = pc1;
            case (op)
                OP_NOP:
                begin
                end
                OP_LXI_B:
                begin
                    gpr_m[GP_C] = b1;
                    gpr_m[GP_B] = b2;
                    nxt = pc_m + 16'd3;
                end
                OP_MOV_BC: gpr_m[GP_B] = gpr_m[GP_C];
                OP_MOV_BD: gpr_m[GP_B] = gpr_m[GP_D];
                OP_MOV_BE: gpr_m[GP_B] = gpr_m[GP_E];
                OP_CMA:    acc_m = ~acc_m;
                OP_ANI:
                begin
                    acc_m = acc_m & b1;
                    flags_m = flags_from(flags_m, acc_m);
                    flags_m[FL_CY] = 1'b0;
                    nxt = pc2;
                end
                OP_RRC:
                begin
                    x = acc_m;
                    acc_m = {x[0], x[7:1]};
                    flags_m[FL_CY] = x[0];
                end
                OP_RAR:
                begin
                    x = acc_m;
                    acc_m = {flags_m[FL_CY], x[7:1]};
                    flags_m[FL_CY] = x[0];
                end
                OP_CPI:
                begin
                    diff = acc_m - b1;
                    flags_m = flags_from(flags_m, diff);
                    flags_m[FL_CY] = (acc_m < b1);
                    nxt = pc2;
                end
                OP_ADD_B: add_to_acc(gpr_m[GP_B]);
                OP_ADD_C: add_to_acc(gpr_m[GP_C]);
                OP_ADD_M: add_to_acc(ram_m[{gpr_m[GP_H], gpr_m[GP_L]}]);
                OP_JNZ:   nxt = flags_m[FL_Z] ? pc_m + 16'd3 : {b2, b1};
                OP_JMP:   nxt = {b2, b1};
                OP_CALL:
                begin
                    ret_addr = pc_m + 16'd3;
                    ram_m[sp_m - 16'd1] = ret_addr[15:8];
                    ram_m[sp_m - 16'd2] = ret_addr[7:0];
                    sp_m = sp_m - 16'd2;
                    nxt = {b2, b1};
                end
                OP_RET:
                begin
                    nxt = {ram_m[sp_m + 16'd1], ram_m[sp_m]};
                    sp_m = sp_m + 16'd2;
                end
                // unknown opcode: sticky halt, pc stays put
                default:
                begin
                    halted_m = 1'b1;
                    st = ST_HALT;
                    nxt = pc_m;
                end
            endcase
            pc_m = nxt;
        end
        v.status = st;
        v.pc     = pc_m;
        v.sp     = sp_m;
        v.a      = acc_m;
        v.b      = gpr_m[GP_B];
        v.c      = gpr_m[GP_C];
        v.flags  = flags_m;
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // result beats are checked before the same edge's step beat is queued
    always @(posedge clk or negedge rst_n)
    begin : watch
        cpu_view_t want;
        if (!rst_n)
        begin
            acc_m    = 8'h00;
            for (int i = 0; i < 6; i++)
                gpr_m[i] = 8'h00;
            pc_m     = 16'h0000;
            sp_m     = 16'h0000;
            flags_m  = 4'h0;
            halted_m = 1'b0;
            expected_steps.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_steps.size() == 0)
                begin
                    $error("result beat with no step pending: tuser %h tdata %h",
                           m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_steps.pop_front();
                    check_field("status", 16'(want.status), 16'(m_axis_tuser));
                    check_field("prog_counter", want.pc, m_axis_tdata[15:0]);
                    check_field("stack_ptr", want.sp, m_axis_tdata[31:16]);
                    check_field("acc", 16'(want.a), 16'(m_axis_tdata[39:32]));
                    check_field("reg_b_out", 16'(want.b), 16'(m_axis_tdata[47:40]));
                    check_field("reg_c_out", 16'(want.c), 16'(m_axis_tdata[55:48]));
                    check_field("flag_bits", 16'(want.flags), 16'(m_axis_tdata[59:56]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                step_cpu(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16], want);
                expected_steps.push_back(want);
            end
            outstanding = expected_steps.size();
        end
    end

endmodule

// ===== dv/cpu8080_subset_step_test.sv =====
module cpu8080_subset_step_test;
    import c8080_pkg::*;

    localparam int ITEM_GOAL = 1750;
    localparam int LONG_HOLD = 200;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int          mismatches;
    int          outstanding;
    logic [15:0] pc_now;
    logic [15:0] sp_now;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int beats_sent   = 0;

    // bytes that hold a defined value; nothing else is ever read
    bit mem_known [0:65535];

    cpu8080_subset_step DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cpu8080_subset_step_check step_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .pc_now        (pc_now),
        .sp_now        (sp_now)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("cpu8080_subset_step_test NOT OK");
        $finish;
    end

    // result side: random stalls, plus long holds on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_served)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_served++;
            end
            else
            begin
                m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // one step beat; entered and left at a falling edge
    task automatic send_beat(input logic kind, input logic [15:0] addr, input logic [7:0] din);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {din, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        if (kind == IN_STORE)
            mem_known[addr] = 1'b1;
        beats_sent++;
    endtask

    // place one instruction at the current pc and execute it
    task automatic run_instr(input logic [7:0] op, input logic [7:0] b1, input logic [7:0] b2);
        logic [15:0] pc;
        logic [15:0] sp;
        int          n_opnd;
        pc = pc_now;
        sp = sp_now;
        case (op)
            OP_LXI_B, OP_JNZ, OP_JMP, OP_CALL: n_opnd = 2;
            OP_ANI, OP_CPI:                    n_opnd = 1;
            default:                           n_opnd = 0;
        endcase
        // a return pops two stack bytes
        if (op == OP_RET)
        begin
            if (!mem_known[sp])
                send_beat(IN_STORE, sp, rand_byte());
            if (!mem_known[sp + 16'd1])
                send_beat(IN_STORE, sp + 16'd1, rand_byte());
        end
        // H and L are never loaded, so ADD M always reads address zero
        if (op == OP_ADD_M && !mem_known[16'h0000])
            send_beat(IN_STORE, 16'h0000, rand_byte());
        send_beat(IN_STORE, pc, op);
        if (n_opnd >= 1 || !mem_known[pc + 16'd1])
            send_beat(IN_STORE, pc + 16'd1, b1);
        if (n_opnd == 2 || !mem_known[pc + 16'd2])
            send_beat(IN_STORE, pc + 16'd2, b2);
        if (op == OP_CALL)
        begin
            mem_known[sp - 16'd1] = 1'b1;
            mem_known[sp - 16'd2] = 1'b1;
        end
        send_beat(IN_EXEC, 16'($urandom), 8'($urandom));
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        logic [7:0] op;
        logic [7:0] bad_op;
        bit         bad_ok;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = IN_STORE;
        s_axis_tdata  = 24'h0;
        rst_n         = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every instruction, flag corners, pc and sp wraparound
        run_instr(OP_LXI_B, 8'hFF, 8'h80);
        run_instr(OP_ADD_B, 8'h00, 8'h00);
        run_instr(OP_ADD_C, 8'h00, 8'h00);
        run_instr(OP_RAR, 8'h00, 8'h00);
        run_instr(OP_RRC, 8'h00, 8'h00);
        run_instr(OP_CMA, 8'h00, 8'h00);
        run_instr(OP_ANI, 8'h00, 8'h00);
        run_instr(OP_JNZ, 8'h00, 8'h40);
        run_instr(OP_CPI, 8'hFF, 8'h00);
        run_instr(OP_MOV_BC, 8'h00, 8'h00);
        run_instr(OP_MOV_BD, 8'h00, 8'h00);
        run_instr(OP_MOV_BE, 8'h00, 8'h00);
        run_instr(OP_ADD_M, 8'h00, 8'h00);
        run_instr(OP_NOP, 8'h00, 8'h00);
        run_instr(OP_JNZ, 8'hFE, 8'hFF);
        run_instr(OP_CALL, 8'h34, 8'h12);
        run_instr(OP_RET, 8'h00, 8'h00);
        run_instr(OP_ANI, 8'hFF, 8'h00);
        run_instr(OP_CPI, 8'h00, 8'h00);
        run_instr(OP_JMP, 8'hFF, 8'hFF);

        // random programs, idle pattern changing per phase
        for (int phase = 0; beats_sent < ITEM_GOAL; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 47;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 47;
                end
                default:
                begin
                    tx_idle_pct  = 37;
                    rx_stall_pct = 37;
                end
            endcase
            // long result hold while steps keep coming
            if (phase == 2 || phase == 6)
                hold_asked++;
            // drain completely before going on
            if (phase == 5)
            begin
                s_axis_tvalid <= 1'b0;
                wait (outstanding == 0);
                @(negedge clk);
            end
            repeat (60)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_beat(IN_STORE, 16'($urandom), 8'($urandom));
                case ($urandom_range(0, 19))
                    0:       op = OP_NOP;
                    1:       op = OP_LXI_B;
                    2:       op = OP_MOV_BC;
                    3:       op = OP_MOV_BD;
                    4:       op = OP_MOV_BE;
                    5:       op = OP_CMA;
                    6:       op = OP_ANI;
                    7:       op = OP_RRC;
                    8:       op = OP_RAR;
                    9:       op = OP_CPI;
                    10:      op = OP_ADD_B;
                    11:      op = OP_ADD_C;
                    12:      op = OP_ADD_M;
                    13, 14:  op = OP_JNZ;
                    15:      op = OP_JMP;
                    16, 17:  op = OP_CALL;
                    default: op = OP_RET;
                endcase
                run_instr(op, rand_byte(), rand_byte());
            end
        end

        // unknown opcode halts for good; steps and stores still answer
        do
        begin
            bad_op = 8'($urandom);
            case (bad_op)
                OP_NOP, OP_LXI_B, OP_MOV_BC, OP_MOV_BD, OP_MOV_BE, OP_CMA, OP_ANI,
                OP_RRC, OP_RAR, OP_CPI, OP_ADD_B, OP_ADD_C, OP_ADD_M, OP_JNZ,
                OP_JMP, OP_CALL, OP_RET: bad_ok = 1'b0;
                default:                 bad_ok = 1'b1;
            endcase
        end
        while (!bad_ok);
        run_instr(bad_op, rand_byte(), rand_byte());
        send_beat(IN_EXEC, 16'hFFFF, 8'hFF);
        send_beat(IN_STORE, 16'($urandom), 8'($urandom));
        send_beat(IN_EXEC, 16'h0000, 8'h00);

        s_axis_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("cpu8080_subset_step_test OK");
        else
            $display("cpu8080_subset_step_test NOT OK");
        $finish;
    end

endmodule
